// ----- sv/one_shot_timer_bank_core_defines.svh -----
// ----------------------------------------------------------------------------
// One-shot timer bank assertion macros
// Shared property forms for the checker of the timer bank core.
// ----------------------------------------------------------------------------
`ifndef ONE_SHOT_TIMER_BANK_CORE_DEFINES_SVH
`define ONE_SHOT_TIMER_BANK_CORE_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define OSTB_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define OSTB_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- sv/ostb_pkg.sv -----
// ----------------------------------------------------------------------------
// One-shot timer bank package
// Operation codes, sequencer states and shared constants.
// ----------------------------------------------------------------------------
package ostb_pkg;

    localparam int NUM_TIMERS_DEF = 8;
    localparam int TIME_BITS_DEF  = 32;
    localparam int OP_W           = 2;
    localparam int TIMER_IDX_W    = 3;
    localparam int PERIOD_W       = 32;

    typedef enum logic [OP_W-1:0] {
        OP_TICK  = 2'd0,
        OP_START = 2'd1,
        OP_STOP  = 2'd2,
        OP_SET   = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_FLUSH
    } t_state;

    typedef enum logic {
        ALU_ADD,
        ALU_SUB
    } t_alu_op;

endpackage

// ----- sv/ostb_alu.sv -----
// ----------------------------------------------------------------------------
// One-shot timer bank shared adder
// Time-wide add/subtract used for the tick increment, the expiry
// computation on start and the wrap-safe expiry test during the scan.
// ----------------------------------------------------------------------------
module ostb_alu #(
    parameter int TIME_BITS = 32
) (
    input  ostb_pkg::t_alu_op     i_op,
    input  logic [TIME_BITS-1:0]  i_a,
    input  logic [TIME_BITS-1:0]  i_b,
    output logic [TIME_BITS-1:0]  o_res
);
    import ostb_pkg::*;

    always_comb begin
        case (i_op)
            ALU_ADD: o_res = i_a + i_b;
            ALU_SUB: o_res = i_a - i_b;
            default: o_res = i_a + i_b;
        endcase
    end

endmodule

// ----- sv/one_shot_timer_bank_core.sv -----
// ----------------------------------------------------------------------------
// One-shot timer bank core
// Bank of one-shot timers with its own tick counter and a sequential
// expiry scan that reports expired timers with notification enabled one beat at a time.
// ----------------------------------------------------------------------------
// Start, stop and set-period beats are taken while idle and leave the block
// idle, so it stays ready for the next beat. A tick beat advances the time
// counter, then the scan walks from the highest index down, timer by timer
// through the single shared adder, and a final step hands out the last
// report marked last. A report that finds the output register still
// occupied holds the scan until the downstream side takes it. Expired
// timers are detected with a signed difference, so the time counter may
// wrap freely as long as no period exceeds half its range.
module one_shot_timer_bank_core #(
    parameter int NUM_TIMERS = ostb_pkg::NUM_TIMERS_DEF,
    parameter int TIME_BITS  = ostb_pkg::TIME_BITS_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    output logic                           o_in_ready,
    input  logic [ostb_pkg::OP_W-1:0]      i_operation,
    input  logic [ostb_pkg::TIMER_IDX_W-1:0] i_timer_index,
    input  logic [ostb_pkg::PERIOD_W-1:0]  i_period_ms,
    input  logic                           i_notify_enable,
    output logic                           o_out_valid,
    input  logic                           i_out_ready,
    output logic [ostb_pkg::TIMER_IDX_W-1:0] o_expired_index,
    output logic                           o_last
);
    import ostb_pkg::*;

    localparam int IDX_W = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;

    t_state                 r_state, n_state;
    logic [TIME_BITS-1:0]   r_now, n_now;
    logic [PERIOD_W-1:0]    r_period [NUM_TIMERS];
    logic [PERIOD_W-1:0]    n_period [NUM_TIMERS];
    logic [TIME_BITS-1:0]   r_expiry [NUM_TIMERS];
    logic [TIME_BITS-1:0]   n_expiry [NUM_TIMERS];
    logic [NUM_TIMERS-1:0]  r_armed, n_armed;
    logic [NUM_TIMERS-1:0]  r_notify, n_notify;
    logic [IDX_W-1:0]       r_scan_idx, n_scan_idx;
    logic                   r_pend_valid, n_pend_valid;
    logic [IDX_W-1:0]       r_pend_idx, n_pend_idx;
    logic                   r_out_valid, n_out_valid;
    logic [TIMER_IDX_W-1:0] r_out_idx, n_out_idx;
    logic                   r_out_last, n_out_last;

    logic                   w_accept;
    logic [IDX_W-1:0]       w_sel;
    logic                   w_in_range;
    logic                   w_out_free;
    t_alu_op                w_alu_op;
    logic [TIME_BITS-1:0]   w_alu_b;
    logic [TIME_BITS-1:0]   w_alu_res;
    logic                   w_due;
    logic                   w_report;
    logic                   w_stall;
    logic                   w_scan_done;

    assign o_in_ready      = (r_state == S_IDLE);
    assign o_out_valid     = r_out_valid;
    assign o_expired_index = r_out_idx;
    assign o_last          = r_out_last;

    assign w_accept   = i_in_valid && (r_state == S_IDLE);
    assign w_sel      = IDX_W'(i_timer_index);
    assign w_in_range = ({29'd0, i_timer_index} < 32'(NUM_TIMERS));
    assign w_out_free = !r_out_valid || i_out_ready;

    // The scan compares now against the stored expiry; otherwise the adder
    // serves the tick increment or the start expiry.
    always_comb begin
        if (r_state == S_SCAN) begin
            w_alu_op = ALU_SUB;
            w_alu_b  = r_expiry[r_scan_idx];
        end else if (i_operation == OP_TICK) begin
            w_alu_op = ALU_ADD;
            w_alu_b  = TIME_BITS'(1);
        end else begin
            w_alu_op = ALU_ADD;
            w_alu_b  = TIME_BITS'(r_period[w_sel]);
        end
    end

    ostb_alu #(
        .TIME_BITS (TIME_BITS)
    ) u_alu (
        .i_op  (w_alu_op),
        .i_a   (r_now),
        .i_b   (w_alu_b),
        .o_res (w_alu_res)
    );

    assign w_due       = r_armed[r_scan_idx] && !w_alu_res[TIME_BITS-1];
    assign w_report    = w_due && r_notify[r_scan_idx];
    // A new report can only displace the held one if the output is free.
    assign w_stall     = w_report && r_pend_valid && !w_out_free;
    assign w_scan_done = (r_scan_idx == '0) && !w_stall;

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (w_accept && (i_operation == OP_TICK)) begin
                    n_state = S_SCAN;
                end
            end
            S_SCAN: begin
                if (w_scan_done) begin
                    n_state = S_FLUSH;
                end
            end
            S_FLUSH: begin
                if (!r_pend_valid || w_out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        n_now        = r_now;
        n_period     = r_period;
        n_expiry     = r_expiry;
        n_armed      = r_armed;
        n_notify     = r_notify;
        n_scan_idx   = r_scan_idx;
        n_pend_valid = r_pend_valid;
        n_pend_idx   = r_pend_idx;
        n_out_valid  = r_out_valid && !i_out_ready;
        n_out_idx    = r_out_idx;
        n_out_last   = r_out_last;

        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    case (i_operation)
                        OP_TICK: begin
                            n_now        = w_alu_res;
                            n_scan_idx   = IDX_W'(NUM_TIMERS - 1);
                            n_pend_valid = 1'b0;
                        end
                        OP_START: begin
                            if (w_in_range && (r_period[w_sel] != '0)) begin
                                n_armed[w_sel]  = 1'b1;
                                n_expiry[w_sel] = w_alu_res;
                            end
                        end
                        OP_STOP: begin
                            if (w_in_range) begin
                                n_armed[w_sel] = 1'b0;
                            end
                        end
                        OP_SET: begin
                            if (w_in_range && (i_period_ms != '0)) begin
                                n_period[w_sel] = i_period_ms;
                                n_notify[w_sel] = i_notify_enable;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_SCAN: begin
                if (!w_stall) begin
                    if (w_due) begin
                        n_armed[r_scan_idx] = 1'b0;
                    end
                    // The newest report is held back until it is known
                    // whether another one follows it.
                    if (w_report) begin
                        if (r_pend_valid) begin
                            n_out_valid = 1'b1;
                            n_out_idx   = TIMER_IDX_W'(r_pend_idx);
                            n_out_last  = 1'b0;
                        end
                        n_pend_valid = 1'b1;
                        n_pend_idx   = r_scan_idx;
                    end
                    if (r_scan_idx != '0) begin
                        n_scan_idx = r_scan_idx - IDX_W'(1);
                    end
                end
            end
            S_FLUSH: begin
                if (r_pend_valid && w_out_free) begin
                    n_out_valid  = 1'b1;
                    n_out_idx    = TIMER_IDX_W'(r_pend_idx);
                    n_out_last   = 1'b1;
                    n_pend_valid = 1'b0;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_now        <= '0;
            r_armed      <= '0;
            r_notify     <= '0;
            r_pend_valid <= 1'b0;
            r_out_valid  <= 1'b0;
            for (int i = 0; i < NUM_TIMERS; i++) begin
                r_period[i] <= '0;
            end
        end else begin
            r_state      <= n_state;
            r_now        <= n_now;
            r_armed      <= n_armed;
            r_notify     <= n_notify;
            r_pend_valid <= n_pend_valid;
            r_out_valid  <= n_out_valid;
            r_period     <= n_period;
        end
    end

    always_ff @(posedge i_clk) begin
        r_expiry   <= n_expiry;
        r_scan_idx <= n_scan_idx;
        r_pend_idx <= n_pend_idx;
        r_out_idx  <= n_out_idx;
        r_out_last <= n_out_last;
    end

endmodule

// ----- sv/ostb_checker.sv -----
// ----------------------------------------------------------------------------
// One-shot timer bank checker
// Port-level properties of the timer bank core, bound to the core module.
// ----------------------------------------------------------------------------
`include "one_shot_timer_bank_core_defines.svh"

module ostb_checker (
    input logic                           i_clk,
    input logic                           i_rst_n,
    input logic                           i_in_valid,
    input logic                           o_in_ready,
    input logic [ostb_pkg::OP_W-1:0]      i_operation,
    input logic                           o_out_valid,
    input logic                           i_out_ready,
    input logic [ostb_pkg::TIMER_IDX_W-1:0] o_expired_index,
    input logic                           o_last
);
    import ostb_pkg::*;

    // A stalled report beat keeps its payload.
    `OSTB_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_out_valid && !i_out_ready, o_out_valid && $stable(o_expired_index) && $stable(o_last), "report beat changed while stalled")

    // Start, stop and set-period complete in the cycle they are taken.
    `OSTB_ASSERT_NEXT(a_op_single, i_clk, i_rst_n, i_in_valid && o_in_ready && (i_operation != OP_TICK), o_in_ready, "block busy after a non-tick beat")

    // A tick always runs a scan before the next beat is taken.
    `OSTB_ASSERT_NEXT(a_tick_busy, i_clk, i_rst_n, i_in_valid && o_in_ready && (i_operation == OP_TICK), !o_in_ready, "tick did not start a scan")

    // While a report not marked last waits, its tick has not finished.
    `OSTB_ASSERT_NOW(a_last_pending, i_clk, i_rst_n, o_out_valid && !o_last, !o_in_ready, "ready before the last report of a tick")

endmodule

bind one_shot_timer_bank_core ostb_checker u_ostb_checker (.*);
